[sv/ple_pkg.sv]
`timescale 1ns / 1ps
// Package: request codes, status codes and the control group sent to every list cell.
package ple_pkg;

	localparam int FUNC_W   = 3;
	localparam int ITEM_W   = 32;
	localparam int POS_W    = 7;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD_FRONT = 3'd0,
		FN_ADD_BACK  = 3'd1,
		FN_INSERT_AT = 3'd2,
		FN_REM_FRONT = 3'd3,
		FN_REM_BACK  = 3'd4,
		FN_REM_AT    = 3'd5,
		FN_GET       = 3'd6,
		FN_CONTAINS  = 3'd7
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// broadcast to every cell in the accept cycle
	typedef struct packed {
		logic load;  // a request is accepted this cycle
		logic ins;   // open a slot at pos, write key there
		logic rem;   // close the slot at pos
		logic rd;    // capture the entry at pos
		logic find;  // compare valid entries against key
	} cell_ctrl_t;

endpackage

[sv/ple_req_if.sv]
`timescale 1ns / 1ps
// Interface: request channel into the list engine.
interface ple_req_if;
	logic                         valid;
	logic                         ready;
	ple_pkg::func_t               func;
	logic [ple_pkg::ITEM_W-1:0]   item_in;
	logic [ple_pkg::POS_W-1:0]    position;

	modport source (output valid, output func, output item_in, output position, input ready);
	modport sink   (input valid, input func, input item_in, input position, output ready);
endinterface

[sv/ple_rsp_if.sv]
`timescale 1ns / 1ps
// Interface: result channel out of the list engine.
interface ple_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ple_pkg::ITEM_W-1:0]    item_out;
	logic                          item_valid;
	ple_pkg::status_t              status;
	logic [ple_pkg::COUNT_W-1:0]   element_count;

	modport source (output valid, output item_out, output item_valid, output status,
		output element_count, input ready);
	modport sink   (input valid, input item_out, input item_valid, input status,
		input element_count, output ready);
endinterface

[sv/ple_cell.sv]
`timescale 1ns / 1ps
// One list cell: holds the entry at a fixed index, shifts with its neighbors, taps and matches.
module ple_cell #(
	parameter int IDX     = 0,
	parameter int VALUE_W = 32,
	parameter int IDX_W   = 7
) (
	input  logic                 clk,
	input  ple_pkg::cell_ctrl_t  ctrl,
	input  logic [IDX_W-1:0]     pos,
	input  logic [IDX_W-1:0]     count,
	input  logic [VALUE_W-1:0]   key,
	input  logic [VALUE_W-1:0]   left,
	input  logic [VALUE_W-1:0]   right,
	output logic [VALUE_W-1:0]   entry,
	output logic [VALUE_W-1:0]   tap,
	output logic                 hit
);
	import ple_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [VALUE_W-1:0] entry_q;
	logic [VALUE_W-1:0] tap_s1;
	logic               hit_s1;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			if (ctrl.ins) begin
				if (MY_IDX == pos) begin
					entry_q <= key;
				end else if (MY_IDX > pos) begin
					entry_q <= left;
				end
			end else if (ctrl.rem && (MY_IDX >= pos)) begin
				entry_q <= right;
			end
			// old value is read here, before the shift lands
			tap_s1 <= (ctrl.rd && (MY_IDX == pos)) ? entry_q : '0;
			hit_s1 <= ctrl.find && (MY_IDX < count) && (entry_q == key);
		end
	end

	assign entry = entry_q;
	assign tap   = tap_s1;
	assign hit   = hit_s1;

endmodule

[sv/positional_list_engine.sv]
`timescale 1ns / 1ps
// Top level: positional list engine built as a row of shifting cells.
// Pipeline: a request passes through stage one (cell update and per-cell tap) and then the output register
//   (reduction of the taps), which holds its result while the sink stalls.
// Throughput: one request per cycle while the output register is not stalled; cells shift, tap or compare
//   in the accept cycle, so the next request sees the updated list at once.
// Reset: arst_n clears the entry count and the pipeline valid flags; cell contents are not cleared.
module positional_list_engine #(
	parameter int DEPTH   = 64,
	parameter int VALUE_W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	ple_req_if.sink      req,
	ple_rsp_if.source    rsp
);
	import ple_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	// list occupancy
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;

	// request decode
	logic               accept;
	logic [IDX_W-1:0]   count_x;
	logic [IDX_W-1:0]   eff_pos;
	logic [VALUE_W-1:0] key;
	cell_ctrl_t         ctrl;
	status_t            status_nxt;

	// stage one: control results waiting for the cell reduction
	logic               s1_vld_q;
	logic               rd_s1;
	status_t            status_s1;
	logic [CNT_W-1:0]   count_s1;
	logic               s1_adv;

	// output register
	logic               out_vld_q;
	logic [ITEM_W-1:0]  item_q;
	logic               item_valid_q;
	status_t            status_q;
	logic [COUNT_W-1:0] elem_count_q;
	logic               out_free;

	// cell row
	logic [VALUE_W-1:0] entry_w [DEPTH];
	logic [VALUE_W-1:0] left_w  [DEPTH];
	logic [VALUE_W-1:0] right_w [DEPTH];
	logic [VALUE_W-1:0] tap_w   [DEPTH];
	logic               hit_w   [DEPTH];
	logic [VALUE_W-1:0] tap_or;
	logic               hit_or;

	// Handshake: the output register frees when empty or taken; stage one
	// advances into it; a new request enters when stage one is free or moving.
	assign out_free  = !out_vld_q || rsp.ready;
	assign s1_adv    = s1_vld_q && out_free;
	assign req.ready = !s1_vld_q || s1_adv;
	assign accept    = req.valid && req.ready;

	assign count_x = IDX_W'(count_q);
	assign key     = VALUE_W'(req.item_in);

	// Decode the request into a position and per-cell commands.
	always_comb begin
		ctrl       = '0;
		ctrl.load  = accept;
		status_nxt = ST_OK;
		count_nxt  = count_q;
		eff_pos    = IDX_W'(req.position);
		case (req.func)
			FN_ADD_FRONT, FN_ADD_BACK, FN_INSERT_AT: begin
				if (req.func == FN_ADD_FRONT) begin
					eff_pos = '0;
				end else if (req.func == FN_ADD_BACK) begin
					eff_pos = count_x;
				end
				// range check comes before the full check
				if (eff_pos > count_x) begin
					status_nxt = ST_RANGE;
				end else if (count_q >= FULL_CNT) begin
					status_nxt = ST_FULL;
				end else begin
					ctrl.ins  = accept;
					count_nxt = count_q + 1'b1;
				end
			end
			FN_REM_FRONT, FN_REM_BACK, FN_REM_AT: begin
				if (req.func == FN_REM_FRONT) begin
					eff_pos = '0;
				end else if (req.func == FN_REM_BACK) begin
					// wraps to all ones on an empty list and fails the check below
					eff_pos = count_x - 1'b1;
				end
				if ((count_q == '0) || (eff_pos >= count_x)) begin
					status_nxt = ST_RANGE;
				end else begin
					ctrl.rem  = accept;
					ctrl.rd   = accept;
					count_nxt = count_q - 1'b1;
				end
			end
			FN_GET: begin
				if (eff_pos >= count_x) begin
					status_nxt = ST_RANGE;
				end else begin
					ctrl.rd = accept;
				end
			end
			FN_CONTAINS: begin
				ctrl.find = accept;
			end
			default: begin
				status_nxt = ST_OK;
			end
		endcase
	end

	// Hold the count; update it on each accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	// Stage one control: load on accept, drop when it moves on without a follower.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (accept) begin
			s1_vld_q <= 1'b1;
		end else if (s1_adv) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= ctrl.rd;
			status_s1 <= status_nxt;
			count_s1  <= count_nxt;
		end
	end

	// Row of cells; the ends see zero past the list edge.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign left_w[g] = '0;
		end else begin : g_mid_l
			assign left_w[g] = entry_w[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_w[g] = '0;
		end else begin : g_mid_r
			assign right_w[g] = entry_w[g+1];
		end

		ple_cell #(
			.IDX     (g),
			.VALUE_W (VALUE_W),
			.IDX_W   (IDX_W)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.pos   (eff_pos),
			.count (count_x),
			.key   (key),
			.left  (left_w[g]),
			.right (right_w[g]),
			.entry (entry_w[g]),
			.tap   (tap_w[g]),
			.hit   (hit_w[g])
		);
	end

	// Only the addressed cell taps a nonzero value, so an OR selects it.
	always_comb begin
		tap_or = '0;
		hit_or = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			tap_or = tap_or | tap_w[i];
			hit_or = hit_or | hit_w[i];
		end
	end

	// Output register: load from stage one, hold while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= s1_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			item_q       <= ITEM_W'(tap_or);
			item_valid_q <= rd_s1 | hit_or;
			status_q     <= status_s1;
			elem_count_q <= COUNT_W'(count_s1);
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.item_out      = item_q;
	assign rsp.item_valid    = item_valid_q;
	assign rsp.status        = status_q;
	assign rsp.element_count = elem_count_q;

	// The list never holds more than DEPTH entries.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above capacity");

	// A request only enters stage one when the previous one leaves it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s1_vld_q) |-> s1_adv)
		else $error("stage one overwritten");

	// The count moves only with an accepted request.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("count changed without a request");

	// A full status only when the list is at capacity.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_vld_q && (status_s1 == ST_FULL)) |-> (count_s1 == FULL_CNT))
		else $error("full status below capacity");

	// A read or removal that returns a value never carries an error status.
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_vld_q && rd_s1) |-> (status_s1 == ST_OK))
		else $error("read flagged with error status");

endmodule
